FILE: rtl/core/evad_pkg.sv
// ----------------------------------------------------------------------------
// evad_pkg: shared definitions for the energy voice activity detector
// Holds the field widths, the status codes and the register indexes.
// ----------------------------------------------------------------------------
package evad_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned ThreshW    = 16;
  localparam int unsigned SilenceW   = 10;
  localparam int unsigned UttW       = 20;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned AppendedW  = 11;
  localparam int unsigned FrameSumW  = 26;
  localparam int unsigned FrameCntW  = 11;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned LoudRunW   = 2;

  // Per-frame status reported with every result.
  typedef enum logic [StatusW-1:0] {
    ST_IDLE        = 3'd0,
    ST_STARTED     = 3'd1,
    ST_CAPTURING   = 3'd2,
    ST_END_ACCEPT  = 3'd3,
    ST_END_SHORT   = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_TH   = 3'd0,
    REG_END_TH     = 3'd1,
    REG_SILENCE    = 3'd2,
    REG_MAX_UTT    = 3'd3,
    REG_MIN_UTT    = 3'd4
  } reg_idx_e;

  localparam logic [ThreshW-1:0]  StartThReset = 16'd1200;
  localparam logic [ThreshW-1:0]  EndThReset   = 16'd600;
  localparam logic [SilenceW-1:0] SilenceReset = 10'd40;
  localparam logic [UttW-1:0]     MaxUttReset  = 20'd160000;
  localparam logic [UttW-1:0]     MinUttReset  = 20'd4800;

endpackage

FILE: rtl/core/energy_voice_activity_detector_top.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_top
// Frames PCM samples, tests each frame's mean level against two thresholds
// and tracks the start, growth and end of an utterance.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        sink       in_valid_i / in_stall_o   sample_i, last_in_frame_i
//  out       source     out_valid_o / out_stall_i status_o .. frame_count_o
//  cfg       sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  A frame end goes through two register stages: the first latches the
//  frame sum, count and threshold products (one 16 x 11 bit multiply each),
//  the second runs the decision logic and loads the result register. Every
//  sample waits while both stages hold a frame and the result is stalled;
//  otherwise a sample is taken every cycle.
//  Reset clears all control state and loads the default register values.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_top #(
  parameter int unsigned MAX_FRAME_SAMPLES   = 1024,
  parameter int unsigned START_FRAMES_NEEDED = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [evad_pkg::SampleW-1:0] sample_i,
  input  logic                                last_in_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [evad_pkg::StatusW-1:0]        status_o,
  output logic [evad_pkg::AppendedW-1:0]      appended_samples_o,
  output logic [evad_pkg::UttW-1:0]           utterance_length_o,
  output logic                                ended_by_max_o,
  output logic [evad_pkg::FrameSumW-1:0]      frame_abs_sum_o,
  output logic [evad_pkg::FrameCntW-1:0]      frame_count_o,
  input  logic                                cfg_we_i,
  input  logic [evad_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [evad_pkg::CfgDataW-1:0]       cfg_data_i
);
  import evad_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned SumW  = $clog2(MAX_FRAME_SAMPLES * 32768 + 1);
  localparam int unsigned ProdW = ThreshW + CntW;
  localparam int unsigned MagW  = SampleW + 1;

  // Configuration registers.
  logic [ThreshW-1:0]  start_th_q, end_th_q;
  logic [SilenceW-1:0] silence_q;
  logic [UttW-1:0]     max_utt_q, min_utt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_th_q <= StartThReset;
      end_th_q   <= EndThReset;
      silence_q  <= SilenceReset;
      max_utt_q  <= MaxUttReset;
      min_utt_q  <= MinUttReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_TH: start_th_q <= cfg_data_i[ThreshW-1:0];
        REG_END_TH:   end_th_q   <= cfg_data_i[ThreshW-1:0];
        REG_SILENCE:  silence_q  <= cfg_data_i[SilenceW-1:0];
        REG_MAX_UTT:  max_utt_q  <= cfg_data_i[UttW-1:0];
        REG_MIN_UTT:  min_utt_q  <= cfg_data_i[UttW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline advance.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_adv, in_acc, fire;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && out_adv;

  // Frame accumulation.
  logic [MagW-1:0] mag, sample_ext;
  logic [SumW-1:0] acc_q, acc_d, sum_inc;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic            frame_end;

  assign sample_ext = {1'b0, sample_i};
  // The most negative sample folds to 32768, which needs the extra bit.
  assign mag     = sample_i[SampleW-1] ? MagW'(17'h10000 - sample_ext) : sample_ext;
  assign sum_inc = acc_q + SumW'(mag);
  assign cnt_inc = cnt_q + CntW'(1);
  assign frame_end = in_acc && (last_in_frame_i || (cnt_inc >= CntW'(MAX_FRAME_SAMPLES)));

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      acc_d = frame_end ? '0 : sum_inc;
      cnt_d = frame_end ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s1_valid_d  = frame_end ? 1'b1 : (out_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  // First stage: frame totals and threshold products.
  logic [SumW-1:0]  s1_sum_q;
  logic [CntW-1:0]  s1_cnt_q;
  logic [ProdW-1:0] s1_sprod_q, s1_eprod_q;

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      s1_sum_q   <= sum_inc;
      s1_cnt_q   <= cnt_inc;
      s1_sprod_q <= ProdW'(start_th_q) * ProdW'(cnt_inc);
      s1_eprod_q <= ProdW'(end_th_q) * ProdW'(cnt_inc);
    end
  end

  // Second stage: utterance decisions.
  logic                capt_q, capt_d;
  logic [LoudRunW-1:0] loud_q, loud_d, loud_n;
  logic [UttW-1:0]     utt_q, utt_d;
  logic [SilenceW-1:0] qrun_q, qrun_d;

  logic                loud, quiet, starting, cap_now, hit_max, hit_quiet;
  logic [UttW-1:0]     utt_base, room, appended, utt_new;
  logic [SilenceW-1:0] qrun_base, qrun_new, need;
  status_e             status_d;
  logic                by_max_d;
  logic [UttW-1:0]     length_d;

  always_comb begin
    loud      = ProdW'(s1_sum_q) >= s1_sprod_q;
    quiet     = ProdW'(s1_sum_q) < s1_eprod_q;
    loud_n    = loud_q;
    starting  = 1'b0;
    utt_base  = utt_q;
    qrun_base = qrun_q;
    status_d  = ST_IDLE;
    if (!capt_q) begin
      if (loud) begin
        loud_n = (loud_q == '1) ? loud_q : loud_q + LoudRunW'(1);
      end else begin
        loud_n = '0;
      end
      starting  = loud_n >= LoudRunW'(START_FRAMES_NEEDED);
      utt_base  = '0;
      qrun_base = '0;
      status_d  = starting ? ST_STARTED : ST_IDLE;
    end else begin
      status_d = ST_CAPTURING;
    end
    cap_now = capt_q || starting;

    room     = (utt_base < max_utt_q) ? UttW'(max_utt_q - utt_base) : '0;
    appended = (UttW'(s1_cnt_q) < room) ? UttW'(s1_cnt_q) : room;
    utt_new  = utt_base + appended;
    if (quiet) begin
      qrun_new = (qrun_base == '1) ? qrun_base : qrun_base + SilenceW'(1);
    end else begin
      qrun_new = '0;
    end
    // A zero silence setting behaves as one quiet frame.
    need      = (silence_q == '0) ? SilenceW'(1) : silence_q;
    hit_max   = utt_new >= max_utt_q;
    hit_quiet = qrun_new >= need;

    capt_d   = capt_q;
    loud_d   = loud_n;
    utt_d    = utt_q;
    qrun_d   = qrun_q;
    by_max_d = 1'b0;
    length_d = '0;
    if (!cap_now) begin
      appended = '0;
    end else begin
      length_d = utt_new;
      if (hit_max || hit_quiet) begin
        by_max_d = hit_max;
        status_d = (utt_new >= min_utt_q) ? ST_END_ACCEPT : ST_END_SHORT;
        capt_d   = 1'b0;
        loud_d   = '0;
        utt_d    = '0;
        qrun_d   = '0;
      end else begin
        capt_d = 1'b1;
        utt_d  = utt_new;
        qrun_d = qrun_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capt_q <= 1'b0;
      loud_q <= '0;
      utt_q  <= '0;
      qrun_q <= '0;
    end else if (fire) begin
      capt_q <= capt_d;
      loud_q <= loud_d;
      utt_q  <= utt_d;
      qrun_q <= qrun_d;
    end
  end

  // Result register.
  status_e                out_status_q;
  logic [AppendedW-1:0]   out_app_q;
  logic [UttW-1:0]        out_len_q;
  logic                   out_by_max_q;
  logic [FrameSumW-1:0]   out_sum_q;
  logic [FrameCntW-1:0]   out_cnt_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= status_d;
      out_app_q    <= AppendedW'(appended);
      out_len_q    <= length_d;
      out_by_max_q <= by_max_d;
      out_sum_q    <= FrameSumW'(s1_sum_q);
      out_cnt_q    <= FrameCntW'(s1_cnt_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign appended_samples_o = out_app_q;
  assign utterance_length_o = out_len_q;
  assign ended_by_max_o     = out_by_max_q;
  assign frame_abs_sum_o    = out_sum_q;
  assign frame_count_o      = out_cnt_q;

  // Assertions.
  a_no_end_no_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_IDLE || status_o == ST_STARTED ||
                    status_o == ST_CAPTURING) |-> !ended_by_max_o)
    else $error("ended_by_max set without an end status");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_IDLE |-> appended_samples_o == '0 &&
                                            utterance_length_o == '0)
    else $error("idle frame reports utterance data");

  a_idle_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !capt_q |-> utt_q == '0 && qrun_q == '0)
    else $error("utterance state left over while idle");

  a_idle_loud_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !capt_q |-> loud_q < LoudRunW'(START_FRAMES_NEEDED))
    else $error("loud run reached start count without capture");

  a_fire_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("frame decision lost before the result register");

endmodule

FILE: verif/energy_voice_activity_detector_checker.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_checker
// Watches the sample, result and register ports of the detector. It keeps its
// own copy of the frame and utterance state, predicts the status of every
// frame and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_checker #(
  parameter int unsigned MAX_FRAME_SAMPLES   = 1024,
  parameter int unsigned START_FRAMES_NEEDED = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [evad_pkg::SampleW-1:0] sample_i,
  input  logic                                last_in_frame_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [evad_pkg::StatusW-1:0]        status_i,
  input  logic [evad_pkg::AppendedW-1:0]      appended_samples_i,
  input  logic [evad_pkg::UttW-1:0]           utterance_length_i,
  input  logic                                ended_by_max_i,
  input  logic [evad_pkg::FrameSumW-1:0]      frame_abs_sum_i,
  input  logic [evad_pkg::FrameCntW-1:0]      frame_count_i,
  input  logic                                cfg_we_i,
  input  logic [evad_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [evad_pkg::CfgDataW-1:0]       cfg_data_i,
  output int unsigned                         mismatch_count_o,
  output int unsigned                         pending_frames_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import evad_pkg::*;

  typedef struct packed {
    status_e                status;
    logic [AppendedW-1:0]   appended;
    logic [UttW-1:0]        utt_len;
    logic                   by_max;
    logic [FrameSumW-1:0]   abs_sum;
    logic [FrameCntW-1:0]   count;
  } frame_status_t;

  frame_status_t expected_frames[$];

  int unsigned start_th;
  int unsigned end_th;
  int unsigned quiet_limit;
  int unsigned max_len;
  int unsigned min_len;

  int unsigned frame_sum;
  int unsigned frame_len;
  bit          capturing;
  int unsigned loud_run;
  int unsigned utt_len;
  int unsigned quiet_run;
  int unsigned mismatches;

  task automatic track_sample(input logic signed [SampleW-1:0] s, input logic last);
    int          v;
    int unsigned sum;
    int unsigned cnt;
    int unsigned room;
    int unsigned need;
    int unsigned appended;
    int unsigned length;
    bit          hit_max;
    bit          hit_quiet;
    bit          by_max;
    status_e     status;
    v = int'(s);
    frame_sum += 32'((v < 0) ? -v : v);
    frame_len += 1;
    if (!last && frame_len < MAX_FRAME_SAMPLES) return;

    sum = frame_sum;
    cnt = frame_len;
    frame_sum = 0;
    frame_len = 0;
    status = ST_IDLE;
    appended = 0;
    length = 0;
    by_max = 1'b0;

    if (!capturing) begin
      if (sum >= start_th * cnt) begin
        if (loud_run < 3) loud_run++;
      end else begin
        loud_run = 0;
      end
      if (loud_run >= START_FRAMES_NEEDED) begin
        capturing = 1'b1;
        utt_len = 0;
        quiet_run = 0;
        status = ST_STARTED;
      end
    end else begin
      status = ST_CAPTURING;
    end

    if (capturing) begin
      room = (utt_len < max_len) ? max_len - utt_len : 0;
      need = (quiet_limit == 0) ? 1 : quiet_limit;
      appended = (cnt < room) ? cnt : room;
      utt_len += appended;
      if (sum < end_th * cnt) begin
        if (quiet_run < 1023) quiet_run++;
      end else begin
        quiet_run = 0;
      end
      hit_max = utt_len >= max_len;
      hit_quiet = quiet_run >= need;
      length = utt_len;
      if (hit_max || hit_quiet) begin
        by_max = hit_max;
        status = (utt_len >= min_len) ? ST_END_ACCEPT : ST_END_SHORT;
        capturing = 1'b0;
        loud_run = 0;
        utt_len = 0;
        quiet_run = 0;
      end
    end

    expected_frames.push_back('{status: status, appended: appended[AppendedW-1:0],
                                utt_len: length[UttW-1:0], by_max: by_max,
                                abs_sum: sum[FrameSumW-1:0], count: cnt[FrameCntW-1:0]});
  endtask

  task automatic check_field(input string name, input longint unsigned expv,
                             input longint unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_status_t exp_frame;
    if (!rst_ni) begin
      start_th = 32'(StartThReset);
      end_th = 32'(EndThReset);
      quiet_limit = 32'(SilenceReset);
      max_len = 32'(MaxUttReset);
      min_len = 32'(MinUttReset);
      frame_sum = 0;
      frame_len = 0;
      capturing = 1'b0;
      loud_run = 0;
      utt_len = 0;
      quiet_run = 0;
      mismatches = 0;
      mismatch_count_o <= 0;
      pending_frames_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          $error("result transfer with status %0d while no frame was pending", status_i);
          mismatches++;
        end else begin
          exp_frame = expected_frames.pop_front();
          check_field("status", exp_frame.status, status_i);
          check_field("appended_samples", exp_frame.appended, appended_samples_i);
          check_field("utterance_length", exp_frame.utt_len, utterance_length_i);
          check_field("ended_by_max", exp_frame.by_max, ended_by_max_i);
          check_field("frame_abs_sum", exp_frame.abs_sum, frame_abs_sum_i);
          check_field("frame_count", exp_frame.count, frame_count_i);
        end
      end

      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_START_TH: start_th = 32'(cfg_data_i[ThreshW-1:0]);
          REG_END_TH:   end_th = 32'(cfg_data_i[ThreshW-1:0]);
          REG_SILENCE:  quiet_limit = 32'(cfg_data_i[SilenceW-1:0]);
          REG_MAX_UTT:  max_len = 32'(cfg_data_i[UttW-1:0]);
          REG_MIN_UTT:  min_len = 32'(cfg_data_i[UttW-1:0]);
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) track_sample(sample_i, last_in_frame_i);

      mismatch_count_o <= mismatches;
      pending_frames_o <= expected_frames.size();
    end
  end

endmodule

FILE: verif/energy_voice_activity_detector_top_tb.sv
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_top_tb
// Feeds the detector directed and random PCM frames under several register
// settings and idle patterns; the checker beside the block judges every frame.
// ----------------------------------------------------------------------------
module energy_voice_activity_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import evad_pkg::*;

  localparam int unsigned MaxFrameSamples   = 1024;
  localparam int unsigned StartFramesNeeded = 2;
  localparam int unsigned SettleCycles      = 6;
  localparam int unsigned WatchdogLimit     = 2000;
  localparam int unsigned PhaseSamples      = 50;
  localparam logic signed [SampleW-1:0] MostPos = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] MostNeg = 16'sh8000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic signed [SampleW-1:0]   sample_i = '0;
  logic                        last_in_frame_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [StatusW-1:0]          status_o;
  logic [AppendedW-1:0]        appended_samples_o;
  logic [UttW-1:0]             utterance_length_o;
  logic                        ended_by_max_o;
  logic [FrameSumW-1:0]        frame_abs_sum_o;
  logic [FrameCntW-1:0]        frame_count_o;
  logic                        cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]          cfg_idx_i = REG_START_TH;
  logic [CfgDataW-1:0]         cfg_data_i = '0;

  int unsigned mismatches;
  int unsigned pending_frames;
  int unsigned src_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned samples_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned cur_start_th = 32'(StartThReset);
  int unsigned cur_end_th = 32'(EndThReset);

  energy_voice_activity_detector_top #(
    .MAX_FRAME_SAMPLES  (MaxFrameSamples),
    .START_FRAMES_NEEDED(StartFramesNeeded)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sample_i           (sample_i),
    .last_in_frame_i    (last_in_frame_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .appended_samples_o (appended_samples_o),
    .utterance_length_o (utterance_length_o),
    .ended_by_max_o     (ended_by_max_o),
    .frame_abs_sum_o    (frame_abs_sum_o),
    .frame_count_o      (frame_count_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  energy_voice_activity_detector_checker #(
    .MAX_FRAME_SAMPLES  (MaxFrameSamples),
    .START_FRAMES_NEEDED(StartFramesNeeded)
  ) i_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .sample_i           (sample_i),
    .last_in_frame_i    (last_in_frame_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_i           (status_o),
    .appended_samples_i (appended_samples_o),
    .utterance_length_i (utterance_length_o),
    .ended_by_max_i     (ended_by_max_o),
    .frame_abs_sum_i    (frame_abs_sum_o),
    .frame_count_i      (frame_count_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .mismatch_count_o   (mismatches),
    .pending_frames_o   (pending_frames)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // Counts cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SampleW-1:0] s, input logic last);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    last_in_frame_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
  endtask

  // A magnitude of 32768 can only be the most negative sample.
  function automatic logic signed [SampleW-1:0] to_sample(input int unsigned mag);
    int v;
    if (mag >= 32768) return MostNeg;
    v = $urandom_range(1) ? -int'(mag) : int'(mag);
    return SampleW'(v);
  endfunction

  task automatic send_frame(input int unsigned len, input int unsigned lo,
                            input int unsigned hi);
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(to_sample($urandom_range(hi, lo)), i == len - 1);
    end
  endtask

  task automatic random_frame();
    int unsigned len;
    int unsigned kind;
    int unsigned lvl;
    len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(8, 1);
    kind = $urandom_range(9);
    if (kind < 4) begin
      send_frame(len, cur_start_th, 32768);
    end else if (kind < 7) begin
      send_frame(len, 0, (cur_end_th == 0) ? 0 : cur_end_th - 1);
    end else if (kind < 9) begin
      send_frame(len, 0, 32768);
    end else begin
      // Mean exactly on a threshold or one below it.
      lvl = $urandom_range(1) ? cur_start_th : cur_end_th;
      if ($urandom_range(1) && lvl > 0) lvl--;
      send_frame(len, lvl, lvl);
    end
  endtask

  // Waits until every frame result has come back and the pipeline is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_frames != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic write_settings(input int unsigned st, input int unsigned et,
                                input int unsigned sil, input int unsigned mx,
                                input int unsigned mn);
    put_reg(REG_START_TH, CfgDataW'(st));
    put_reg(REG_END_TH, CfgDataW'(et));
    put_reg(REG_SILENCE, CfgDataW'(sil));
    put_reg(REG_MAX_UTT, CfgDataW'(mx));
    put_reg(REG_MIN_UTT, CfgDataW'(mn));
    cfg_we_i <= 1'b0;
    cur_start_th = st;
    cur_end_th = et;
  endtask

  initial begin
    int unsigned st;
    int unsigned phase_end;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: two loud frames start an utterance, then quiet and loud frames.
    send_sample(MostPos, 1'b1);
    send_sample(MostNeg, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd1200, 1'b0);
    send_sample(-16'sd1200, 1'b1);
    send_sample(16'sd599, 1'b1);
    drain();

    // The maximum drops below the current length while capturing.
    write_settings(1200, 600, 0, 3, 4800);
    send_sample(16'sd0, 1'b1);
    send_sample(MostNeg, 1'b1);
    send_sample(MostPos, 1'b1);
    for (int i = 0; i < 5; i++) send_sample(MostPos, i == 4);
    drain();

    // A zero maximum ends the utterance on the frame that starts it.
    write_settings(1200, 600, 0, 0, 0);
    send_sample(MostNeg, 1'b1);
    send_sample(MostNeg, 1'b1);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_gap_pct = 53; sink_stall_pct = 0;  end
        2: begin src_gap_pct = 0;  sink_stall_pct = 53; end
        default: begin src_gap_pct = 35; sink_stall_pct = 35; end
      endcase
      case (p)
        4: write_settings(0, 0, 1, 20'hFFFFF, 20'hFFFFF);
        5: write_settings(32768, 32768, 1023, 1, 0);
        default: begin
          st = $urandom_range(8000, 500);
          write_settings(st, $urandom_range(st, 0), (p == 6) ? 0 : $urandom_range(4, 1),
                         $urandom_range(300, 10), $urandom_range(150, 0));
        end
      endcase
      phase_end = samples_sent + PhaseSamples;
      while (samples_sent < phase_end) random_frame();
      drain();
    end

    if (mismatches == 0 && pending_frames == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
